[design/bsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int SLOTS     = 64;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int GRP_SZ    = 8;
    localparam int OFS_W     = $clog2(GRP_SZ);
    localparam int GRP_W     = $clog2(SLOTS / GRP_SZ);
    localparam int PCT_W     = 7;
    localparam int DIVD_W    = 13;
    localparam int STEP_W    = $clog2(DIVD_W);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PREP,
        S_DIVIDE
    } t_state;

endpackage

[design/bitmap_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// First-fit slot allocator over an in-use bitmap, with used count and
// truncated used percentage on every result.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// command   in         start && !busy            i_command, i_slot_index
// result    out        o_done (one cycle)        o_status, o_granted_slot,
//                                                o_used_count, o_used_percent
// config    in         i_cfg_we                  i_cfg_wdata (active_slots)
//
// Allocate: a first-fit search (8 slots scanned per cycle), then a load state
// and a shared restoring divider for the percentage. Free and query: the
// load state and the divider. busy is high throughout; o_done strobes in
// the first idle cycle.
// Reset and every config write taken while idle clear the bitmap and used count.
// The receiver cannot stall; o_done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [IDX_W-1:0]   o_granted_slot,
    output logic [CNT_W-1:0]   o_used_count,
    output logic [PCT_W-1:0]   o_used_percent
);

    t_state               r_state, n_state;
    logic [SLOTS-1:0]     r_map, n_map;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [CNT_W-1:0]     r_active, n_active;
    logic [GRP_W-1:0]     r_grp, n_grp;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [DIVD_W-1:0]    r_quot, n_quot;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [1:0]           r_status, n_status;
    logic [IDX_W-1:0]     r_grant, n_grant;
    logic                 r_done, n_done;

    logic [CNT_W-1:0]     eff_n;
    logic                 accept;
    logic [IDX_W-1:0]     base;
    logic [GRP_SZ-1:0]    grp_free;
    logic                 grp_hit;
    logic [OFS_W-1:0]     hit_pos;
    logic                 search_end;
    logic [CNT_W:0]       rem_sh;
    logic                 rem_ge;
    logic                 div_last;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        if (r_active == '0) begin
            eff_n = CNT_W'(1);
        end else if (r_active > CNT_W'(SLOTS)) begin
            eff_n = CNT_W'(SLOTS);
        end else begin
            eff_n = r_active;
        end
    end

    // search window: one group of slots per cycle
    assign base = {r_grp, {OFS_W{1'b0}}};

    always_comb begin
        grp_hit = 1'b0;
        hit_pos = '0;
        for (int k = 0; k < GRP_SZ; k++) begin
            grp_free[k] = !r_map[int'(base) + k] &&
                          ((CNT_W'(base) + CNT_W'(k)) < eff_n);
        end
        for (int k = GRP_SZ - 1; k >= 0; k--) begin
            if (grp_free[k]) begin
                grp_hit = 1'b1;
                hit_pos = OFS_W'(k);
            end
        end
    end

    assign search_end = (r_grp == {GRP_W{1'b1}}) ||
                        ((CNT_W'(base) + CNT_W'(GRP_SZ)) >= eff_n);

    // shared restoring divider step
    assign rem_sh   = {r_rem, r_quot[DIVD_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, eff_n};
    assign div_last = (r_step == STEP_W'(DIVD_W - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_command == CMD_ALLOC) ? S_SEARCH : S_PREP;
                end
            end
            S_SEARCH: begin
                if (grp_hit || search_end) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_map    = r_map;
        n_used   = r_used;
        n_active = r_active;
        n_grp    = r_grp;
        n_step   = r_step;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_status = r_status;
        n_grant  = r_grant;
        n_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_active = i_cfg_wdata;
                    n_map    = '0;
                    n_used   = '0;
                end else if (accept) begin
                    n_grp    = '0;
                    n_status = ST_OK;
                    n_grant  = '0;
                    unique case (i_command)
                        CMD_ALLOC: begin
                            n_status = ST_FULL;
                        end
                        CMD_FREE: begin
                            if (CNT_W'(i_slot_index) >= eff_n) begin
                                n_status = ST_RANGE;
                            end else if (!r_map[i_slot_index]) begin
                                n_status = ST_NOT_USED;
                            end else begin
                                n_map[i_slot_index] = 1'b0;
                                n_used              = r_used - CNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (grp_hit) begin
                    n_map[{r_grp, hit_pos}] = 1'b1;
                    n_used   = r_used + CNT_W'(1);
                    n_grant  = {r_grp, hit_pos};
                    n_status = ST_OK;
                end else begin
                    n_grp = r_grp + GRP_W'(1);
                end
            end
            S_PREP: begin
                // used * 100 = used * (64 + 32 + 4)
                n_quot = {r_used, 6'b0} + DIVD_W'({r_used, 5'b0})
                       + DIVD_W'({r_used, 2'b0});
                n_rem  = '0;
                n_step = '0;
            end
            S_DIVIDE: begin
                n_rem  = rem_ge ? CNT_W'(rem_sh - {1'b0, eff_n}) : CNT_W'(rem_sh);
                n_quot = {r_quot[DIVD_W-2:0], rem_ge};
                n_step = r_step + STEP_W'(1);
                n_done = div_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_map    <= '0;
            r_used   <= '0;
            r_active <= CNT_W'(SLOTS);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_map    <= n_map;
            r_used   <= n_used;
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp    <= n_grp;
        r_step   <= n_step;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_slot = r_grant;
    assign o_used_count   = r_used;
    assign o_used_percent = r_quot[PCT_W-1:0];

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy fell without a result strobe");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == CNT_W'($countones(r_map)))
        else $error("used count out of step with bitmap");

    a_percent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_used_percent <= PCT_W'(100)))
        else $error("used percentage above 100");

    a_grant_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_OK)) |-> (CNT_W'(o_granted_slot) < eff_n))
        else $error("granted slot outside active range");
`endif

endmodule

[verif/tb_bitmap_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator
// Self-checking bench for the first-fit slot allocator. A directed table
// covers reset state, pool full, out-of-range and unused frees, the spare
// command code and saturation of the slot count. Random traffic then runs
// over several slot counts and sender idle rates. Every result strobe is
// compared field by field against its table row or an in-bench bitmap pool model.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator;
    import bsa_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         N_PHASES  = 9;
    localparam int         PHASE_LEN = 190;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] count;
        logic [PCT_W-1:0] pct;
    } pool_result_t;

    typedef struct packed {
        logic             wr_cfg;
        logic [CNT_W-1:0] cfg_val;
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        logic             typed;
        pool_result_t     res;
    } stim_row_t;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic [1:0]         i_command      = CMD_QUERY;
    logic [IDX_W-1:0]   i_slot_index   = '0;
    logic               i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata    = '0;
    logic               busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_granted_slot;
    logic [CNT_W-1:0]   o_used_count;
    logic [PCT_W-1:0]   o_used_percent;

    // model of the pool
    logic               pool_map [SLOTS];
    int unsigned        pool_used;
    logic [CNT_W-1:0]   pool_cfg;

    pool_result_t       pending_results [$];
    stim_row_t          dir_tbl [$];
    int                 err_count = 0;
    int                 idle_pct  = 0;

    bitmap_slot_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_slot_index   (i_slot_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_used_count   (o_used_count),
        .o_used_percent (o_used_percent)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void clear_pool_model(logic [CNT_W-1:0] val);
        pool_cfg  = val;
        pool_used = 0;
        for (int i = 0; i < SLOTS; i++) pool_map[i] = 1'b0;
    endfunction

    function automatic pool_result_t predict_pool_op(logic [1:0] cmd, logic [IDX_W-1:0] idx);
        pool_result_t r;
        int unsigned  eff;
        eff = pool_cfg;
        if (eff == 0) eff = 1;
        if (eff > SLOTS) eff = SLOTS;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_ALLOC) begin
            r.status = ST_FULL;
            for (int i = 0; i < eff; i++) begin
                if (!pool_map[i]) begin
                    pool_map[i] = 1'b1;
                    pool_used++;
                    r.slot   = i[IDX_W-1:0];
                    r.status = ST_OK;
                    break;
                end
            end
        end else if (cmd == CMD_FREE) begin
            if (idx >= eff) begin
                r.status = ST_RANGE;
            end else if (!pool_map[idx]) begin
                r.status = ST_NOT_USED;
            end else begin
                pool_map[idx] = 1'b0;
                pool_used--;
            end
        end
        r.count = pool_used[CNT_W-1:0];
        r.pct   = PCT_W'((pool_used * 100) / eff);
        return r;
    endfunction

    function automatic stim_row_t mk_row(int wr, int val, logic [1:0] cmd,
                                         int idx, int typed,
                                         logic [1:0] st, int slot,
                                         int cnt, int pct);
        stim_row_t row;
        row.wr_cfg     = (wr != 0);
        row.cfg_val    = CNT_W'(val);
        row.cmd        = cmd;
        row.idx        = IDX_W'(idx);
        row.typed      = (typed != 0);
        row.res.status = st;
        row.res.slot   = IDX_W'(slot);
        row.res.count  = CNT_W'(cnt);
        row.res.pct    = PCT_W'(pct);
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // single transfer on the command channel
    task automatic push_cmd(logic [1:0] cmd, logic [IDX_W-1:0] idx, logic typed,
                            pool_result_t typed_res);
        int           gap;
        pool_result_t exp_res;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= cmd;
        i_slot_index <= idx;
        do @(posedge i_clk); while (busy);
        exp_res = predict_pool_op(cmd, idx);
        pending_results.push_back(typed ? typed_res : exp_res);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slot_count(logic [CNT_W-1:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        clear_pool_model(val);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CNT_W'($urandom_range(127));
    endtask

    task automatic random_pool_op(int alloc_w);
        int               r;
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        int               live [$];
        r   = $urandom_range(99);
        idx = IDX_W'($urandom_range(SLOTS - 1));
        if (r < alloc_w) begin
            cmd = CMD_ALLOC;
        end else if (r < 88) begin
            cmd = CMD_FREE;
            for (int i = 0; i < SLOTS; i++) if (pool_map[i]) live.push_back(i);
            if (live.size() != 0 && $urandom_range(3) != 0)
                idx = IDX_W'(live[$urandom_range(live.size() - 1)]);
        end else if (r < 94) begin
            cmd = CMD_QUERY;
        end else begin
            cmd = CMD_SPARE;
        end
        push_cmd(cmd, idx, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        pool_result_t want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_status), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_granted_slot !== want.slot)
                    report_mismatch("granted_slot", int'(o_granted_slot),
                                    int'(want.slot));
                if (o_used_count !== want.count)
                    report_mismatch("used_count", int'(o_used_count), int'(want.count));
                if (o_used_percent !== want.pct)
                    report_mismatch("used_percent", int'(o_used_percent),
                                    int'(want.pct));
            end
        end
    end

    initial begin
        logic [CNT_W-1:0] cfg_list [N_PHASES];
        int               alloc_w;

        clear_pool_model(7'd64);

        // reset state, 64 slots
        dir_tbl.push_back(mk_row(0, 0,   CMD_QUERY, 0,  1, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  0,  1, ST_NOT_USED, 0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  63, 1, ST_NOT_USED, 0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 63, 1, ST_OK,       0, 1, 1));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 0,  1, ST_OK,       1, 2, 3));
        dir_tbl.push_back(mk_row(0, 0,   CMD_SPARE, 63, 1, ST_OK,       0, 2, 3));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  0,  1, ST_OK,       0, 1, 1));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 42, 0, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  1,  0, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  1,  0, ST_OK,       0, 0, 0));
        // two slots: full and out of range
        dir_tbl.push_back(mk_row(1, 2,   CMD_ALLOC, 0,  1, ST_OK,       0, 1, 50));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 0,  1, ST_OK,       1, 2, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 0,  1, ST_FULL,     0, 2, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  2,  1, ST_RANGE,    0, 2, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  63, 1, ST_RANGE,    0, 2, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  1,  0, ST_OK,       0, 0, 0));
        // zero acts as one slot
        dir_tbl.push_back(mk_row(1, 0,   CMD_ALLOC, 0,  1, ST_OK,       0, 1, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 0,  1, ST_FULL,     0, 1, 100));
        dir_tbl.push_back(mk_row(0, 0,   CMD_FREE,  1,  1, ST_RANGE,    0, 1, 100));
        // above the pool size saturates
        dir_tbl.push_back(mk_row(1, 127, CMD_ALLOC, 21, 0, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_QUERY, 42, 0, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(1, 1,   CMD_FREE,  0,  0, ST_OK,       0, 0, 0));
        dir_tbl.push_back(mk_row(0, 0,   CMD_ALLOC, 0,  0, ST_OK,       0, 0, 0));

        cfg_list = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd37,
                     CNT_W'($urandom_range(1, 127)), 7'd65, 7'd8};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[k]) begin
            if (dir_tbl[k].wr_cfg) write_slot_count(dir_tbl[k].cfg_val);
            push_cmd(dir_tbl[k].cmd, dir_tbl[k].idx, dir_tbl[k].typed, dir_tbl[k].res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_slot_count(cfg_list[p]);
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 72;
                2: idle_pct = 0;
                default: idle_pct = 34;
            endcase
            alloc_w = 70;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 48 == 0) alloc_w = (n % 96 == 0) ? 75 : 30;
                if (n == PHASE_LEN / 2) drain_results();
                random_pool_op(alloc_w);
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/bsa_pkg.sv
design/bitmap_slot_allocator.sv
verif/tb_bitmap_slot_allocator.sv
